@@ hw/rtl/hsv2rgb_pkg.sv @@
// Shared constants and types for the HSV to RGB converter.
package hsv2rgb_pkg;

  // Channel and field widths
  localparam int unsigned HUE_W   = 16;
  localparam int unsigned LEVEL_W = 8;

  // Number of register stages from input beat to output register
  localparam int unsigned NUM_STAGES = 9;

  // Color wheel constants
  localparam logic [16:0] HUE_RANGE   = 17'd360;
  localparam logic [8:0]  SECTOR_SPAN = 9'd60;
  localparam logic [7:0]  FULL_LEVEL  = 8'd255;

  // Reciprocals for division by a constant (multiply, then shift)
  // hue / 360   : (hue * 46604)  >> 24, exact for 16-bit hue
  // angle / 60  : (angle * 1093) >> 16, exact for angle < 360
  // x / 60      : (x * 17477)    >> 20, exact for x <= 255 * 60
  // x / 255     : (x * 131587)   >> 25, exact for x <= 255 * 255
  localparam logic [15:0] RECIP_360      = 16'd46604;
  localparam int unsigned SHIFT_360      = 24;
  localparam logic [10:0] RECIP_SECTOR   = 11'd1093;
  localparam int unsigned SHIFT_SECTOR   = 16;
  localparam logic [14:0] RECIP_60       = 15'd17477;
  localparam int unsigned SHIFT_60       = 20;
  localparam logic [17:0] RECIP_255      = 18'd131587;
  localparam int unsigned SHIFT_255      = 25;

  // 60-degree sector of the hue circle
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

@@ hw/rtl/hsv2rgb_if.sv @@
// Valid/ready channel interfaces for HSV input beats and RGB output beats.
interface hsv2rgb_hsv_if import hsv2rgb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HUE_W-1:0]   hue;
  logic [LEVEL_W-1:0] saturation;
  logic [LEVEL_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_rgb_if import hsv2rgb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

@@ hw/rtl/hsv_to_rgb_converter_core.sv @@
// Pipelined HSV to RGB converter with mirrored red/blue placement.
//
//  channel  dir  handshake     payload
//  hsv      in   valid/ready   hue[15:0], saturation[7:0], brightness[7:0]
//  rgb      out  valid/ready   red[7:0], green[7:0], blue[7:0]
//
// One beat per clock unless the output stalls, through a nine-stage pipeline
// (hue wrap, sector split, three products, two reciprocal divides, select).
// All stages advance together when the output register is empty or taken;
// a stall freezes every stage, so nothing is dropped or repeated.
// Synchronous reset clears the stage valid bits only; payload is not reset.
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  hsv2rgb_hsv_if.sink          hsv,
  hsv2rgb_rgb_if.source        rgb
);

  logic [NUM_STAGES-1:0] vld;
  logic                  en;

  // Stage 1: quotient of hue by 360
  logic [31:0]        quo_prod;
  logic [7:0]         s1_quo;
  logic [HUE_W-1:0]   s1_hue;
  logic [LEVEL_W-1:0] s1_sat, s1_val;

  // Stage 2: wrapped angle
  logic [16:0]        quo_x360;
  logic [16:0]        angle_diff;
  logic [8:0]         s2_angle;
  logic [LEVEL_W-1:0] s2_sat, s2_val;

  // Stage 3: sector index
  logic [19:0]        sect_prod;
  sector_t            s3_sector;
  logic [8:0]         s3_angle;
  logic [LEVEL_W-1:0] s3_sat, s3_val;

  // Stage 4: remainder within sector
  logic [8:0]         frac_diff;
  sector_t            s4_sector;
  logic [5:0]         s4_frac;
  logic [LEVEL_W-1:0] s4_sat, s4_val;

  // Stage 5: products
  logic [13:0]        s5_sf, s5_sg;
  logic [15:0]        s5_pnum;
  sector_t            s5_sector;
  logic [LEVEL_W-1:0] s5_val;

  // Stage 6: divide by 60 and 255
  logic [28:0]        div_a_prod, div_b_prod;
  logic [33:0]        div_p_prod;
  logic [LEVEL_W-1:0] s6_a, s6_b, s6_p;
  sector_t            s6_sector;
  logic [LEVEL_W-1:0] s6_val;

  // Stage 7: scaled numerators for q and t
  logic [15:0]        s7_qnum, s7_tnum;
  logic [LEVEL_W-1:0] s7_p;
  sector_t            s7_sector;
  logic [LEVEL_W-1:0] s7_val;

  // Stage 8: q and t levels
  logic [33:0]        div_q_prod, div_t_prod;
  logic [LEVEL_W-1:0] s8_q, s8_t, s8_p;
  sector_t            s8_sector;
  logic [LEVEL_W-1:0] s8_val;

  // Stage 9: output register
  logic [LEVEL_W-1:0] red, green, blue;
  logic [LEVEL_W-1:0] red_next, green_next, blue_next;

  // Advance the whole pipeline when the output register is free or drained
  assign en        = !vld[NUM_STAGES-1] || rgb.ready;
  assign hsv.ready = en;
  assign rgb.valid = vld[NUM_STAGES-1];
  assign rgb.red   = red;
  assign rgb.green = green;
  assign rgb.blue  = blue;

  // Shift valid bits along with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_STAGES-2:0], hsv.valid};
    end
  end

  // Datapath arithmetic between stages
  always_comb begin
    quo_prod   = 32'(hsv.hue) * 32'(RECIP_360);
    quo_x360   = 17'(s1_quo) * HUE_RANGE;
    angle_diff = {1'b0, s1_hue} - quo_x360;
    sect_prod  = 20'(s2_angle) * 20'(RECIP_SECTOR);
    frac_diff  = s3_angle - 9'(s3_sector) * SECTOR_SPAN;
    div_a_prod = 29'(s5_sf) * 29'(RECIP_60);
    div_b_prod = 29'(s5_sg) * 29'(RECIP_60);
    div_p_prod = 34'(s5_pnum) * 34'(RECIP_255);
    div_q_prod = 34'(s7_qnum) * 34'(RECIP_255);
    div_t_prod = 34'(s7_tnum) * 34'(RECIP_255);
  end

  // Place v, p, q, t on the channels by sector (red and blue mirrored)
  always_comb begin
    case (s8_sector)
      SEC_RED_YEL: begin
        red_next = s8_p;   green_next = s8_t;   blue_next = s8_val;
      end
      SEC_YEL_GRN: begin
        red_next = s8_p;   green_next = s8_val; blue_next = s8_q;
      end
      SEC_GRN_CYN: begin
        red_next = s8_t;   green_next = s8_val; blue_next = s8_p;
      end
      SEC_CYN_BLU: begin
        red_next = s8_val; green_next = s8_q;   blue_next = s8_p;
      end
      SEC_BLU_MAG: begin
        red_next = s8_val; green_next = s8_p;   blue_next = s8_t;
      end
      default: begin
        red_next = s8_q;   green_next = s8_p;   blue_next = s8_val;
      end
    endcase
  end

  // Pipeline payload registers; hold everything while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      s1_quo    <= quo_prod[SHIFT_360 +: 8];
      s1_hue    <= hsv.hue;
      s1_sat    <= hsv.saturation;
      s1_val    <= hsv.brightness;

      s2_angle  <= angle_diff[8:0];
      s2_sat    <= s1_sat;
      s2_val    <= s1_val;

      s3_sector <= sector_t'(sect_prod[SHIFT_SECTOR +: 3]);
      s3_angle  <= s2_angle;
      s3_sat    <= s2_sat;
      s3_val    <= s2_val;

      s4_frac   <= frac_diff[5:0];
      s4_sector <= s3_sector;
      s4_sat    <= s3_sat;
      s4_val    <= s3_val;

      s5_sf     <= 14'(s4_sat) * 14'(s4_frac);
      s5_sg     <= 14'(s4_sat) * 14'(6'(SECTOR_SPAN) - s4_frac);
      s5_pnum   <= 16'(s4_val) * 16'(FULL_LEVEL - s4_sat);
      s5_sector <= s4_sector;
      s5_val    <= s4_val;

      s6_a      <= div_a_prod[SHIFT_60 +: LEVEL_W];
      s6_b      <= div_b_prod[SHIFT_60 +: LEVEL_W];
      s6_p      <= div_p_prod[SHIFT_255 +: LEVEL_W];
      s6_sector <= s5_sector;
      s6_val    <= s5_val;

      s7_qnum   <= 16'(s6_val) * 16'(FULL_LEVEL - s6_a);
      s7_tnum   <= 16'(s6_val) * 16'(FULL_LEVEL - s6_b);
      s7_p      <= s6_p;
      s7_sector <= s6_sector;
      s7_val    <= s6_val;

      s8_q      <= div_q_prod[SHIFT_255 +: LEVEL_W];
      s8_t      <= div_t_prod[SHIFT_255 +: LEVEL_W];
      s8_p      <= s7_p;
      s8_sector <= s7_sector;
      s8_val    <= s7_val;

      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
    end
  end

  // Wrapped angle and its split stay inside the color wheel
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (s4_frac < 6'(SECTOR_SPAN)) && (s3_angle < 9'(HUE_RANGE)))
    else $error("angle or sector remainder out of range");

  // No derived level ever exceeds the value component
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (s8_p <= s8_val) && (s8_q <= s8_val) && (s8_t <= s8_val))
    else $error("p, q or t exceeds brightness");

  // A stall freezes the last two stages
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && $stable(s8_q) && $stable(s8_t) && $stable(red))
    else $error("pipeline moved during stall");

endmodule

@@ test/hsv_rgb_color_checker.sv @@
`timescale 1ns / 100ps
// Color checker: predicts RGB levels for each accepted HSV beat and compares output beats.
module hsv_rgb_color_checker
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hsv2rgb_hsv_if      hsv,
  hsv2rgb_rgb_if      rgb,
  output int unsigned error_count,
  output int unsigned pending,
  output int unsigned checked
);

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_level_t;

  rgb_level_t expected_px[$];

  // Convert one HSV pixel with truncating division; red and blue are mirrored
  function automatic rgb_level_t convert_hsv(logic [HUE_W-1:0] hue_in,
                                             logic [LEVEL_W-1:0] sat_in,
                                             logic [LEVEL_W-1:0] val_in);
    int unsigned angle, frac, s, v, lo, dn, up;
    sector_t     sector;
    rgb_level_t  px;
    angle  = hue_in % HUE_RANGE;
    sector = sector_t'(angle / SECTOR_SPAN);
    frac   = angle % SECTOR_SPAN;
    s      = sat_in;
    v      = val_in;
    lo     = (v * (FULL_LEVEL - s)) / FULL_LEVEL;
    dn     = (v * (FULL_LEVEL - (s * frac) / SECTOR_SPAN)) / FULL_LEVEL;
    up     = (v * (FULL_LEVEL - (s * (SECTOR_SPAN - frac)) / SECTOR_SPAN)) / FULL_LEVEL;
    case (sector)
      SEC_RED_YEL: begin
        px.red = lo[7:0]; px.green = up[7:0]; px.blue = v[7:0];
      end
      SEC_YEL_GRN: begin
        px.red = lo[7:0]; px.green = v[7:0];  px.blue = dn[7:0];
      end
      SEC_GRN_CYN: begin
        px.red = up[7:0]; px.green = v[7:0];  px.blue = lo[7:0];
      end
      SEC_CYN_BLU: begin
        px.red = v[7:0];  px.green = dn[7:0]; px.blue = lo[7:0];
      end
      SEC_BLU_MAG: begin
        px.red = v[7:0];  px.green = lo[7:0]; px.blue = up[7:0];
      end
      default: begin
        px.red = dn[7:0]; px.green = lo[7:0]; px.blue = v[7:0];
      end
    endcase
    return px;
  endfunction

  // Queue a prediction per input beat, then match each output beat in order
  always @(posedge clk) begin
    rgb_level_t got;
    rgb_level_t want;
    if (!rst) begin
      if (hsv.valid && hsv.ready)
        expected_px.push_back(convert_hsv(hsv.hue, hsv.saturation, hsv.brightness));
      if (rgb.valid && rgb.ready) begin
        got.red   = rgb.red;
        got.green = rgb.green;
        got.blue  = rgb.blue;
        if (expected_px.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected rgb beat r=%0d g=%0d b=%0d",
                     $realtime, got.red, got.green, got.blue);
        end else begin
          want = expected_px.pop_front();
          checked++;
          if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
          begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: rgb mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       $realtime, want.red, want.green, want.blue,
                       got.red, got.green, got.blue);
          end
        end
      end
    end
    pending <= expected_px.size();
  end

endmodule

@@ test/tb_hsv_to_rgb_converter_core.sv @@
`timescale 1ns / 100ps
// Testbench top: drives HSV pixel beats and output backpressure, gives the verdict.
module tb_hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
();

  localparam int unsigned RANDOM_PIXELS = 800;
  localparam int unsigned CALM_FROM     = 680;
  localparam int unsigned IDLE_LIMIT    = 1000;
  localparam int unsigned NUM_DIRECTED  = 20;

  // hue, saturation, value: sector edges, wraps and level extremes
  localparam logic [31:0] DIRECTED_PX [NUM_DIRECTED] = '{
    {16'd0,     8'd255, 8'd255}, {16'd59,    8'd255, 8'd255},
    {16'd60,    8'd255, 8'd255}, {16'd119,   8'd255, 8'd255},
    {16'd120,   8'd255, 8'd255}, {16'd179,   8'd255, 8'd255},
    {16'd180,   8'd255, 8'd255}, {16'd239,   8'd255, 8'd255},
    {16'd240,   8'd255, 8'd255}, {16'd299,   8'd255, 8'd255},
    {16'd300,   8'd255, 8'd255}, {16'd359,   8'd255, 8'd255},
    {16'd360,   8'd255, 8'd255}, {16'd65535, 8'd255, 8'd255},
    {16'd30,    8'd0,   8'd255}, {16'd90,    8'd255, 8'd0},
    {16'd210,   8'd0,   8'd0},   {16'd65520, 8'd128, 8'd200},
    {16'd45,    8'd1,   8'd254}, {16'd330,   8'd254, 8'd1}
  };

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned pixels_sent;
  int unsigned wrapped_hues;
  int unsigned error_count;
  int unsigned pending;
  int unsigned checked;

  hsv2rgb_hsv_if hsv ();
  hsv2rgb_rgb_if rgb ();

  hsv_to_rgb_converter_core uut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv),
    .rgb (rgb)
  );

  hsv_rgb_color_checker color_check (
    .clk         (clk),
    .rst         (rst),
    .hsv         (hsv),
    .rgb         (rgb),
    .error_count (error_count),
    .pending     (pending),
    .checked     (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hold ready low for random-length bursts; keep it high once calm
  always @(posedge clk) begin
    if (rst || calm) begin
      rgb.ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      rgb.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      rgb.ready <= 1'b1;
    end
  end

  // End the run if no beat moves on either side for too long
  always @(posedge clk) begin
    if ((hsv.valid && hsv.ready) || (rgb.valid && rgb.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d still expected", idle_cycles, pending);
      $display("tb_hsv_to_rgb_converter_core: errors");
      $finish;
    end
  end

  // Present one pixel and hold it until the block takes it
  task automatic push_pixel(input logic [HUE_W-1:0] hue_in,
                            input logic [LEVEL_W-1:0] sat_in,
                            input logic [LEVEL_W-1:0] val_in);
    hsv.valid      <= 1'b1;
    hsv.hue        <= hue_in;
    hsv.saturation <= sat_in;
    hsv.brightness <= val_in;
    @(posedge clk);
    while (!hsv.ready) @(posedge clk);
    pixels_sent++;
    if (hue_in >= HUE_RANGE) wrapped_hues++;
  endtask

  // Drop valid for a burst of idle cycles, scrambling the payload meanwhile
  task automatic idle_burst();
    int unsigned gap;
    gap = $urandom_range(1, 9);
    hsv.valid <= 1'b0;
    repeat (gap) begin
      hsv.hue        <= HUE_W'($urandom);
      hsv.saturation <= LEVEL_W'($urandom);
      hsv.brightness <= LEVEL_W'($urandom);
      @(posedge clk);
    end
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 5)
      return HUE_W'($urandom_range(0, 359));
    else if (mode < 8)
      return HUE_W'($urandom);
    else
      return HUE_W'($urandom_range(0, 181) * 360 + $urandom_range(0, 5) * 60
                    + ($urandom_range(0, 1) ? 59 : 0));
  endfunction

  initial begin
    rst            = 1'b1;
    calm           = 1'b0;
    pixels_sent    = 0;
    wrapped_hues   = 0;
    hsv.valid      = 1'b0;
    hsv.hue        = '0;
    hsv.saturation = '0;
    hsv.brightness = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk sector edges, hue wraps and level extremes back to back
    for (int i = 0; i < NUM_DIRECTED; i++)
      push_pixel(DIRECTED_PX[i][31:16], DIRECTED_PX[i][15:8], DIRECTED_PX[i][7:0]);

    // Random pixels with idle bursts, then a calm stretch at full rate
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == CALM_FROM) calm <= 1'b1;
      if (i < CALM_FROM && $urandom_range(0, 5) == 0) idle_burst();
      push_pixel(pick_hue(), pick_level(), pick_level());
    end
    hsv.valid <= 1'b0;

    // Drain the pipeline, then give any stray beat time to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NUM_STAGES * 4) @(posedge clk);

    $display("covered %0d pixels (%0d directed, %0d with hue of 360 or more), %0d compared",
             pixels_sent, NUM_DIRECTED, wrapped_hues, checked);
    $display("all six sectors, sector edges and 0/255 saturation and value were exercised");
    if (error_count == 0)
      $display("tb_hsv_to_rgb_converter_core: clean");
    else
      $display("tb_hsv_to_rgb_converter_core: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_if.sv
hw/rtl/hsv_to_rgb_converter_core.sv
test/hsv_rgb_color_checker.sv
test/tb_hsv_to_rgb_converter_core.sv
